FILE: sv/kplp_pkg.sv
// Shared types and constants for the key press and long-press detector.
package kplp_pkg;

  localparam int KEY_W      = 24;
  localparam int TIME_W     = 32;
  localparam int KEY_PAD_W  = 32;
  localparam int IDX_OUT_W  = 5;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_MASK = CFG_IDX_W'(1);

  localparam logic [TIME_W-1:0] TIMEOUT_RST  = TIME_W'(500);
  localparam logic [KEY_W-1:0]  NUM_MASK_RST = KEY_W'(1023);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_DONE
  } walk_state_t;

  typedef struct packed {
    logic             valid;
    logic             ev;
    logic             lp;
    logic [KEY_W-1:0] keys;
  } scan_res_t;

endpackage

FILE: sv/kplp_ifs.sv
// Request channels: scan input, scan result and configuration write.
interface kplp_in_if;
  import kplp_pkg::*;
  logic              valid;
  logic              ready;
  logic [KEY_W-1:0]  key_bitmap;
  logic [TIME_W-1:0] time_now;
  modport source (output valid, key_bitmap, time_now, input ready);
  modport sink (input valid, key_bitmap, time_now, output ready);
endinterface

interface kplp_out_if;
  import kplp_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 event_res;
  logic [KEY_W-1:0]     keys_out;
  logic                 long_hold;
  logic                 number_pressed;
  logic [IDX_OUT_W-1:0] number_index;
  modport source (output valid, event_res, keys_out, long_hold, number_pressed,
                  number_index, input ready);
  modport sink (input valid, event_res, keys_out, long_hold, number_pressed,
                number_index, output ready);
endinterface

interface kplp_cfg_if;
  import kplp_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: sv/kplp_time_ram.sv
// Press-time memory: one entry per key, registered read, per-entry valid bits.
module kplp_time_ram #(
  parameter int DEPTH = 24,
  parameter int WIDTH = 32,
  parameter int AW    = 5
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] valid_r;
  logic [WIDTH-1:0] rdata_r;
  logic             rvalid_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rvalid_r <= 1'b0;
    end else begin
      if (we) begin
        valid_r[waddr] <= 1'b1;
      end
      rvalid_r <= valid_r[raddr];
    end
  end

  assign rdata = rvalid_r ? rdata_r : '0;

endmodule

FILE: sv/kplp_walker.sv
// Scan sequencer: change detection, per-key walk over the press-time memory.
module kplp_walker #(
  parameter int NUM_KEYS  = 24,
  parameter int TIME_BITS = 32,
  parameter int KIDX_W    = 5
) (
  input  logic                     clk,
  input  logic                     rst_n,
  kplp_in_if.sink                  in_if,
  input  logic [kplp_pkg::TIME_W-1:0] timeout,
  output kplp_pkg::scan_res_t      res,
  input  logic                     res_take,
  output logic                     mem_we,
  output logic [KIDX_W-1:0]        mem_addr,
  output logic [TIME_BITS-1:0]     mem_wdata,
  input  logic [TIME_BITS-1:0]     mem_rdata
);
  import kplp_pkg::*;

  localparam int CMP_W = (TIME_BITS > TIME_W) ? TIME_BITS : TIME_W;
  localparam logic [KIDX_W-1:0] LAST_IDX = KIDX_W'(NUM_KEYS - 1);

  walk_state_t          state_r, state_nxt;
  logic [KIDX_W-1:0]    idx_r, idx_nxt;
  logic [KIDX_W-1:0]    chk_idx_r, chk_idx_nxt;
  logic                 chk_r, chk_nxt;
  logic [KEY_W-1:0]     keys_r, keys_nxt;
  logic [KEY_W-1:0]     prev_r, prev_nxt;
  logic [KEY_W-1:0]     fresh_r, fresh_nxt;
  logic [TIME_BITS-1:0] now_r, now_nxt;
  logic                 chg_r, chg_nxt;
  logic                 lp_r, lp_nxt;
  logic [NUM_KEYS-1:0]  flags_r, flags_nxt;
  logic [KEY_PAD_W-1:0] keys_pad, fresh_pad, in_fresh_pad;
  logic [TIME_BITS-1:0] held;
  logic                 in_ready;

  assign keys_pad     = KEY_PAD_W'(keys_r);
  assign fresh_pad    = KEY_PAD_W'(fresh_r);
  assign in_fresh_pad = KEY_PAD_W'(in_if.key_bitmap & ~prev_r);
  assign held         = now_r - mem_rdata;
  assign in_if.ready  = in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      chk_r   <= 1'b0;
      prev_r  <= '0;
      flags_r <= '0;
      lp_r    <= 1'b0;
      chg_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      chk_r   <= chk_nxt;
      prev_r  <= prev_nxt;
      flags_r <= flags_nxt;
      lp_r    <= lp_nxt;
      chg_r   <= chg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r     <= idx_nxt;
    chk_idx_r <= chk_idx_nxt;
    keys_r    <= keys_nxt;
    fresh_r   <= fresh_nxt;
    now_r     <= now_nxt;
  end

  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    chk_idx_nxt = idx_r;
    chk_nxt     = 1'b0;
    keys_nxt    = keys_r;
    prev_nxt    = prev_r;
    fresh_nxt   = fresh_r;
    now_nxt     = now_r;
    chg_nxt     = chg_r;
    lp_nxt      = lp_r;
    flags_nxt   = flags_r;
    in_ready    = 1'b0;
    mem_we      = 1'b0;
    mem_addr    = idx_r;
    mem_wdata   = now_r;
    res.valid   = 1'b0;
    res.ev      = chg_r | lp_r;
    res.lp      = lp_r;
    res.keys    = (chg_r | lp_r) ? keys_r : '0;

    // long-press check on data read last cycle
    if (chk_r && (CMP_W'(held) >= CMP_W'(timeout))) begin
      flags_nxt[chk_idx_r] = 1'b1;
      lp_nxt               = 1'b1;
    end

    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_if.valid) begin
          keys_nxt  = in_if.key_bitmap;
          prev_nxt  = in_if.key_bitmap;
          fresh_nxt = in_if.key_bitmap & ~prev_r;
          now_nxt   = TIME_BITS'(in_if.time_now);
          chg_nxt   = (in_if.key_bitmap != prev_r);
          lp_nxt    = 1'b0;
          idx_nxt   = '0;
          flags_nxt = flags_r & ~in_fresh_pad[NUM_KEYS-1:0];
          if (in_if.key_bitmap == prev_r && in_if.key_bitmap == '0) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        if (chg_r) begin
          mem_we = fresh_pad[5'(idx_r)];
        end else begin
          chk_nxt = keys_pad[5'(idx_r)] & ~flags_r[idx_r];
        end
        idx_nxt = idx_r + KIDX_W'(1);
        if (idx_r == LAST_IDX) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        res.valid = 1'b1;
        if (res_take) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: sv/kplp_out_stage.sv
// Result register: numeric-key decode and output request channel.
module kplp_out_stage (
  input  logic                    clk,
  input  logic                    rst_n,
  input  kplp_pkg::scan_res_t     res,
  output logic                    res_take,
  input  logic [kplp_pkg::KEY_W-1:0] num_mask,
  kplp_out_if.source              out_if
);
  import kplp_pkg::*;

  logic                 valid_r, valid_nxt;
  logic                 ev_r, lp_r, num_r;
  logic [KEY_W-1:0]     keys_r;
  logic [IDX_OUT_W-1:0] nidx_r;
  logic [KEY_W-1:0]     nums;
  logic [IDX_OUT_W-1:0] nidx;

  assign nums     = res.keys & num_mask;
  assign res_take = res.valid & (~valid_r | out_if.ready);

  always_comb begin
    nidx = '0;
    for (int i = KEY_W - 1; i >= 0; i--) begin
      if (nums[i]) begin
        nidx = IDX_OUT_W'(i);
      end
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (res_take) begin
      valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      ev_r   <= res.ev;
      lp_r   <= res.lp;
      keys_r <= res.keys;
      num_r  <= |nums;
      nidx_r <= nidx;
    end
  end

  assign out_if.valid          = valid_r;
  assign out_if.event_res      = ev_r;
  assign out_if.keys_out       = keys_r;
  assign out_if.long_hold      = lp_r;
  assign out_if.number_pressed = num_r;
  assign out_if.number_index   = nidx_r;

endmodule

FILE: sv/key_press_long_press_detector.sv
// Key press and long-press detector, top level.
// One scan is accepted at a time. A scan whose bitmap is unchanged and zero
// goes straight to the done state, and its result is registered once the
// output stage can take it, after which the detector is idle again.
// Any other scan walks the press-time memory one key per cycle, set by the
// single read/write port of that memory, then passes the drain state before
// its result is offered in the done state. The result sits in an output
// register, so the next scan is taken while it waits. Press times reset to
// zero through per-key valid bits; no clearing pass is needed.
// Configuration writes are always ready and must only come while idle.
module key_press_long_press_detector #(
  parameter int NUM_KEYS  = 24,
  parameter int TIME_BITS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  kplp_in_if.sink    in_if,
  kplp_out_if.source out_if,
  kplp_cfg_if.sink   cfg_if
);
  import kplp_pkg::*;

  localparam int KIDX_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

  logic [TIME_W-1:0]    timeout_r;
  logic [KEY_W-1:0]     num_mask_r;
  scan_res_t            res;
  logic                 res_take;
  logic                 mem_we;
  logic [KIDX_W-1:0]    mem_addr;
  logic [TIME_BITS-1:0] mem_wdata;
  logic [TIME_BITS-1:0] mem_rdata;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r  <= TIMEOUT_RST;
      num_mask_r <= NUM_MASK_RST;
    end else if (cfg_if.valid) begin
      if (cfg_if.index == CFG_TIMEOUT) begin
        timeout_r <= TIME_W'(cfg_if.data);
      end else if (cfg_if.index == CFG_NUM_MASK) begin
        num_mask_r <= cfg_if.data[KEY_W-1:0];
      end
    end
  end

  kplp_walker #(
    .NUM_KEYS  (NUM_KEYS),
    .TIME_BITS (TIME_BITS),
    .KIDX_W    (KIDX_W)
  ) u_walker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .timeout   (timeout_r),
    .res       (res),
    .res_take  (res_take),
    .mem_we    (mem_we),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .mem_rdata (mem_rdata)
  );

  kplp_time_ram #(
    .DEPTH (NUM_KEYS),
    .WIDTH (TIME_BITS),
    .AW    (KIDX_W)
  ) u_time_ram (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (mem_we),
    .waddr (mem_addr),
    .wdata (mem_wdata),
    .raddr (mem_addr),
    .rdata (mem_rdata)
  );

  kplp_out_stage u_out_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .res      (res),
    .res_take (res_take),
    .num_mask (num_mask_r),
    .out_if   (out_if)
  );

endmodule

FILE: verif/key_event_check.sv
`timescale 1ns / 1ps
// Key event predictor and result comparator for the key press detector.
module key_event_check (
  input  logic clk,
  input  logic rst_n,
  kplp_in_if   in_ch,
  kplp_out_if  out_ch,
  kplp_cfg_if  cfg_ch,
  output int   mismatches,
  output int   outstanding,
  output int   n_events,
  output int   n_long
);
  import kplp_pkg::*;

  typedef struct packed {
    logic                 ev;
    logic [KEY_W-1:0]     keys;
    logic                 lp;
    logic                 num;
    logic [IDX_OUT_W-1:0] idx;
  } key_event_t;

  logic [TIME_W-1:0] hold_limit;
  logic [KEY_W-1:0]  numeric_keys;
  logic [KEY_W-1:0]  last_keys;
  logic [KEY_W-1:0]  reported;
  logic [TIME_W-1:0] pressed_at [KEY_W];
  key_event_t        pending_events [$];

  task automatic predict_scan(input logic [KEY_W-1:0] keys, input logic [TIME_W-1:0] now,
                              output key_event_t r);
    logic [KEY_W-1:0]  fresh;
    logic [KEY_W-1:0]  carried;
    logic [KEY_W-1:0]  nums;
    logic [TIME_W-1:0] held;
    r = '0;
    carried = '0;
    if (keys != last_keys) begin
      fresh = keys & ~last_keys;
      for (int k = 0; k < KEY_W; k++) begin
        if (fresh[k]) begin
          pressed_at[k] = now;
          reported[k] = 1'b0;
        end
      end
      carried = keys;
      r.ev = 1'b1;
    end else if (keys != '0) begin
      for (int k = 0; k < KEY_W; k++) begin
        held = now - pressed_at[k];
        if (keys[k] && !reported[k] && held >= hold_limit) begin
          r.lp = 1'b1;
          r.ev = 1'b1;
          carried = keys;
          reported[k] = 1'b1;
        end
      end
    end
    last_keys = keys;
    nums = carried & numeric_keys;
    r.keys = carried;
    r.num = |nums;
    for (int k = KEY_W - 1; k >= 0; k--) begin
      if (nums[k]) r.idx = IDX_OUT_W'(k);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    key_event_t want;
    key_event_t got;
    if (!rst_n) begin
      hold_limit = TIMEOUT_RST;
      numeric_keys = NUM_MASK_RST;
      last_keys = '0;
      reported = '0;
      for (int k = 0; k < KEY_W; k++) pressed_at[k] = '0;
      pending_events.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          CFG_TIMEOUT:  hold_limit = cfg_ch.data[TIME_W-1:0];
          CFG_NUM_MASK: numeric_keys = cfg_ch.data[KEY_W-1:0];
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.event_res, out_ch.keys_out, out_ch.long_hold,
                out_ch.number_pressed, out_ch.number_index};
        if (pending_events.size() == 0) begin
          mismatches++;
          $display("%0t: result with no scan pending, expected none, got %0h", $time, got);
        end else begin
          want = pending_events.pop_front();
          check_field("event_res", 32'(want.ev), 32'(got.ev));
          check_field("keys_out", 32'(want.keys), 32'(got.keys));
          check_field("long_hold", 32'(want.lp), 32'(got.lp));
          check_field("number_pressed", 32'(want.num), 32'(got.num));
          check_field("number_index", 32'(want.idx), 32'(got.idx));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        predict_scan(in_ch.key_bitmap, in_ch.time_now, want);
        if (want.ev) n_events++;
        if (want.lp) n_long++;
        pending_events.push_back(want);
      end
    end
    outstanding <= pending_events.size();
  end

endmodule

FILE: verif/key_press_long_press_detector_test.sv
`timescale 1ns / 1ps
// Testbench top: scan and register stimulus, watchdog and verdict for the detector.
module key_press_long_press_detector_test;
  import kplp_pkg::*;

  localparam int IDLE_LIMIT    = 4000;
  localparam int SETTLE_CYCLES = 40;
  localparam int N_PHASES      = 8;
  localparam int PHASE_SCANS   = 190;
  localparam int KEY_IDX_W     = $clog2(KEY_W);
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_FIRST = CFG_NUM_MASK + 1'b1;

  logic clk;
  logic rst_n;

  kplp_in_if  in_ch ();
  kplp_out_if out_ch ();
  kplp_cfg_if cfg_ch ();

  int mismatches;
  int outstanding;
  int n_events;
  int n_long;
  int n_scans;
  int n_settings;
  int send_idle_pct;
  int recv_stall_pct;
  int idle_cycles;

  logic [TIME_W-1:0] clock_now;
  logic [TIME_W-1:0] cur_timeout;
  logic [TIME_W-1:0] phase_timeout [N_PHASES];
  logic [KEY_W-1:0]  phase_mask [N_PHASES];

  key_press_long_press_detector dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  key_event_check event_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_ch      (cfg_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .n_events    (n_events),
    .n_long      (n_long)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("%0t: no request moved for %0d cycles", $time, IDLE_LIMIT);
      $display("key_press_long_press_detector_test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_scan(input logic [KEY_W-1:0] keys, input logic [TIME_W-1:0] t);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.key_bitmap <= keys;
    in_ch.time_now <= t;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    n_scans++;
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input logic [TIME_W-1:0] timeout, input logic [KEY_W-1:0] mask);
    logic [CFG_IDX_W-1:0] spare;
    spare = CFG_IDX_W'(CFG_SPARE_FIRST +
                       $urandom_range(0, (2 ** CFG_IDX_W) - 1 - CFG_SPARE_FIRST));
    settle();
    set_reg(CFG_TIMEOUT, timeout);
    set_reg(CFG_NUM_MASK, CFG_DATA_W'(mask) | ($urandom() & ~CFG_DATA_W'({KEY_W{1'b1}})));
    set_reg(spare, $urandom());
    cur_timeout = timeout;
    n_settings++;
  endtask

  function automatic logic [TIME_W-1:0] hold_gap(input logic [TIME_W-1:0] lim);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 35) return $urandom_range(0, lim / 4);
    if (r < 55) return lim - 1'b1;
    if (r < 75) return lim;
    if (r < 85) return lim + $urandom_range(1, 3);
    return $urandom();
  endfunction

  function automatic logic [KEY_W-1:0] pick_keys();
    logic [KEY_W-1:0]     k;
    logic [KEY_IDX_W-1:0] b;
    k = '0;
    if ($urandom_range(0, 3) == 0) return KEY_W'($urandom());
    repeat ($urandom_range(1, 3)) begin
      b = KEY_IDX_W'($urandom_range(0, KEY_W - 1));
      k[b] = 1'b1;
    end
    return k;
  endfunction

  // press, hold across the timeout, maybe press or release more, maybe let go
  task automatic key_gesture();
    logic [KEY_W-1:0] keys;
    int unsigned r;
    keys = pick_keys();
    clock_now = clock_now + $urandom_range(1, 1000);
    send_scan(keys, clock_now);
    repeat ($urandom_range(1, 5)) begin
      r = $urandom_range(0, 99);
      if (r < 15) keys = keys | pick_keys();
      else if (r < 25) keys = keys & KEY_W'($urandom());
      clock_now = clock_now + hold_gap(cur_timeout);
      send_scan(keys, clock_now);
    end
    if ($urandom_range(0, 1) == 1) begin
      clock_now = clock_now + $urandom_range(0, 100);
      send_scan('0, clock_now);
    end
  endtask

  task automatic random_scans(input int count);
    int stop_at;
    int unsigned r;
    stop_at = n_scans + count;
    while (n_scans < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 75) begin
        key_gesture();
      end else if (r < 90) begin
        send_scan(KEY_W'($urandom()), $urandom());
      end else begin
        clock_now = clock_now + $urandom_range(0, 50);
        send_scan('0, clock_now);
      end
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.key_bitmap <= '0;
    in_ch.time_now <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= CFG_TIMEOUT;
    cfg_ch.data <= '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    n_scans = 0;
    n_settings = 1;
    clock_now = '0;
    cur_timeout = TIMEOUT_RST;
    phase_timeout = '{TIMEOUT_RST, '0, '1, TIME_W'($urandom_range(1, 3000)),
                      TIME_W'(1), TIME_W'($urandom()), TIME_W'(100), '1 - 1'b1};
    phase_mask = '{NUM_MASK_RST, '1, '0, KEY_W'($urandom()),
                   KEY_W'(1) << (KEY_W - 1), KEY_W'(1), KEY_W'($urandom()), '1};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: timeout 500, numeric keys 0..9; held times wrap past zero
    send_scan(24'h000000, 32'h0000_0000);
    send_scan(24'hFFFFFF, 32'hFFFF_FFF0);
    send_scan(24'hFFFFFF, 32'h0000_01E3);
    send_scan(24'hFFFFFF, 32'h0000_01E4);
    send_scan(24'hFFFFFF, 32'h0000_01E5);
    send_scan(24'hFFFC00, 32'h0000_01F0);
    send_scan(24'hFFFFFF, 32'h0000_0200);
    send_scan(24'hFFFFFF, 32'h0000_03F4);
    send_scan(24'h800000, 32'h0000_03F8);
    send_scan(24'h000000, 32'h0000_03F9);
    send_scan(24'h000000, 32'hFFFF_FFFF);
    send_scan(24'h000200, 32'h0000_1000);
    send_scan(24'h000200, 32'h0000_11F3);
    send_scan(24'h000200, 32'h0000_11F4);
    send_scan(24'h000300, 32'h0000_2000);
    send_scan(24'h000300, 32'h0000_21F4);

    // zero timeout fires on the first unchanged scan
    configure('0, '1);
    send_scan(24'h800001, 32'h0000_0010);
    send_scan(24'h800001, 32'h0000_0010);
    send_scan(24'h800000, 32'h0000_0010);

    // largest timeout needs a hold of exactly 2^32 - 1 ticks
    configure('1, KEY_W'(1) << (KEY_W - 1));
    send_scan(24'h000000, 32'h0000_0000);
    send_scan(24'h800000, 32'h0000_0064);
    send_scan(24'h800000, 32'h0000_0063);
    send_scan(24'h400000, 32'h0000_0064);

    for (int p = 0; p < N_PHASES; p++) begin
      configure(phase_timeout[p], phase_mask[p]);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
        default: begin send_idle_pct = 20; recv_stall_pct = 20; end
      endcase
      random_scans(PHASE_SCANS);
    end

    settle();
    $display("Ran %0d scans under %0d register settings: %0d key events, %0d long presses.",
             n_scans, n_settings, n_events, n_long);
    if (mismatches == 0) begin
      $display("key_press_long_press_detector_test passed");
    end else begin
      $display("key_press_long_press_detector_test failed");
    end
    $finish;
  end

endmodule
